/* rtl/pti_pkg.sv */
// ----------------------------------------------------------------------------
// pti_pkg
// Shared constants, codes and types of the prefix tree insert and lookup block.
// ----------------------------------------------------------------------------
package pti_pkg;

   localparam int NODES    = 4096;
   localparam int ALPHABET = 26;
   localparam int NODE_W   = $clog2(NODES);
   localparam int COUNT_W  = NODE_W + 1;
   localparam int KIND_W   = 2;
   localparam int LETTER_W = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_EXACT  = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_PREFIX = KIND_W'(2);

   typedef logic [ALPHABET-1:0][NODE_W-1:0] row_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_LOOK,
      S_ZERO,
      S_MARK,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic              row_re;
      logic              row_we;
      logic [NODE_W-1:0] row_addr;
      row_type           row_wdata;
      logic              end_re;
      logic              end_we;
      logic [NODE_W-1:0] end_addr;
      logic              end_wdata;
   } store_cmd_type;

endpackage

/* rtl/pti_req_if.sv */
// ----------------------------------------------------------------------------
// pti_req_if
// Request channel: one letter of a word with its operation and last mark.
// ----------------------------------------------------------------------------
interface pti_req_if
   import pti_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [LETTER_W-1:0] letter;
   logic                last;

   modport source (output valid, output kind, output letter, output last, input ready);
   modport sink   (input valid, input kind, input letter, input last, output ready);
endinterface

/* rtl/pti_rsp_if.sv */
// ----------------------------------------------------------------------------
// pti_rsp_if
// Response channel: one result per word.
// ----------------------------------------------------------------------------
interface pti_rsp_if;
   logic valid;
   logic ready;
   logic answer;
   logic status;

   modport source (output valid, output answer, output status, input ready);
   modport sink   (input valid, input answer, input status, output ready);
endinterface

/* rtl/prefix_tree_insert_lookup_top.sv */
// ----------------------------------------------------------------------------
// prefix_tree_insert_lookup_top
// Prefix tree over a fixed node pool; one request per letter, one response
// per word.
// ----------------------------------------------------------------------------
// channel   dir   payload                 transfer
// req_ch    in    kind, letter, last      valid & ready
// rsp_ch    out   answer, status          valid & ready
//
// A letter issues a child row read, then decides on that row (a letter out of
// the alphabet, or one after a miss, skips both). Creating a node adds S_ZERO to
// clear the new node's row (single row port). The last letter adds an end-mark read, then the response load.
// A waiting response stalls only the next word end, not the letters before it.
// After reset, S_INIT clears the root row before the first request is taken.
// ----------------------------------------------------------------------------
module prefix_tree_insert_lookup_top
   import pti_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pti_req_if.sink       req_ch,
   pti_rsp_if.source     rsp_ch
);

   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    cursor_ff, cursor_in;
   logic [COUNT_W-1:0]   nodes_used_ff, nodes_used_in;
   logic                 missed_ff, missed_in;
   logic                 overflowed_ff, overflowed_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [LETTER_W-1:0]  letter_ff, letter_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 answer_ff, answer_in;
   logic                 status_ff, status_in;

   store_cmd_type        cmd;
   row_type              row_rd;
   row_type              row_mod;
   logic                 end_rd;
   logic                 accept;
   logic [NODE_W-1:0]    child;
   logic                 slot_free;
   logic                 word_ok;

   pti_store u_store (
      .clock  (clock),
      .cmd    (cmd),
      .row_rd (row_rd),
      .end_rd (end_rd)
   );

   assign accept    = req_ch.valid && req_ch.ready;
   assign child     = row_rd[letter_ff];
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign word_ok   = !missed_ff && !overflowed_ff;

   always_comb begin
      row_mod          = row_rd;
      row_mod[letter_ff] = nodes_used_ff[NODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cursor_ff     <= '0;
         nodes_used_ff <= COUNT_W'(1);
         missed_ff     <= 1'b0;
         overflowed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         nodes_used_ff <= nodes_used_in;
         missed_ff     <= missed_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      answer_ff <= answer_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      nodes_used_in = nodes_used_ff;
      missed_in     = missed_ff;
      overflowed_in = overflowed_ff;
      kind_in       = kind_ff;
      letter_in     = letter_ff;
      last_in       = last_ff;
      answer_in     = answer_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      req_ch.ready  = 1'b0;

      cmd           = '0;
      cmd.row_addr  = cursor_ff;
      cmd.end_addr  = cursor_ff;

      case (state_ff)
         S_INIT: begin
            cmd.row_we    = 1'b1;
            cmd.row_addr  = '0;
            cmd.row_wdata = '0;
            state_in      = S_IDLE;
         end
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (accept) begin
               kind_in   = req_ch.kind;
               letter_in = req_ch.letter;
               last_in   = req_ch.last;
               if (!word_ok || (int'(req_ch.letter) >= ALPHABET)) begin
                  missed_in = missed_ff || word_ok;
                  state_in  = req_ch.last ? S_MARK : S_IDLE;
               end else begin
                  cmd.row_re = 1'b1;
                  state_in   = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            state_in = last_ff ? S_MARK : S_IDLE;
            if (child != '0) begin
               cursor_in = child;
            end else if (kind_ff != KIND_INSERT) begin
               missed_in = 1'b1;
            end else if (nodes_used_ff >= COUNT_W'(NODES)) begin
               overflowed_in = 1'b1;
            end else begin
               cmd.row_we    = 1'b1;
               cmd.row_wdata = row_mod;
               cmd.end_we    = 1'b1;
               cmd.end_addr  = nodes_used_ff[NODE_W-1:0];
               cmd.end_wdata = 1'b0;
               cursor_in     = nodes_used_ff[NODE_W-1:0];
               nodes_used_in = nodes_used_ff + COUNT_W'(1);
               state_in      = S_ZERO;
            end
         end
         S_ZERO: begin
            cmd.row_we    = 1'b1;
            cmd.row_wdata = '0;
            state_in      = last_ff ? S_MARK : S_IDLE;
         end
         S_MARK: begin
            cmd.end_re = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = overflowed_ff;
               case (kind_ff)
                  KIND_INSERT: answer_in = word_ok;
                  KIND_EXACT:  answer_in = word_ok && end_rd;
                  default:     answer_in = word_ok;
               endcase
               if (word_ok && (kind_ff == KIND_INSERT)) begin
                  cmd.end_we    = 1'b1;
                  cmd.end_wdata = 1'b1;
               end
               cursor_in     = '0;
               missed_in     = 1'b0;
               overflowed_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.answer = answer_ff;
   assign rsp_ch.status = status_ff;

endmodule

/* rtl/pti_store.sv */
// ----------------------------------------------------------------------------
// pti_store
// Node storage: child row memory (one row per node) and end-mark memory.
// ----------------------------------------------------------------------------
module pti_store
   import pti_pkg::*;
(
   input  logic          clock,
   input  store_cmd_type cmd,
   output row_type       row_rd,
   output logic          end_rd
);

   row_type row_mem [NODES];
   logic    end_mem [NODES];
   row_type row_rd_ff;
   logic    end_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.row_we) begin
         row_mem[cmd.row_addr] <= cmd.row_wdata;
      end
      if (cmd.row_re) begin
         row_rd_ff <= row_mem[cmd.row_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.end_we) begin
         end_mem[cmd.end_addr] <= cmd.end_wdata;
      end
      if (cmd.end_re) begin
         end_rd_ff <= end_mem[cmd.end_addr];
      end
   end

   assign row_rd = row_rd_ff;
   assign end_rd = end_rd_ff;

endmodule

/* rtl/pti_checker.sv */
// ----------------------------------------------------------------------------
// pti_checker
// Port-level checks of the prefix tree block, bound to the top level.
// ----------------------------------------------------------------------------
module pti_checker
   import pti_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_answer,
   input logic rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_answer) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   a_overflow_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_answer)
      else $error("pool-full response with answer set");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("request taken while word end pending");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("channel active right after reset");

endmodule

bind prefix_tree_insert_lookup_top pti_checker u_pti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_last   (req_ch.last),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_answer (rsp_ch.answer),
   .rsp_status (rsp_ch.status)
);

/* tb/sv/tb_prefix_tree_insert_lookup_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prefix_tree_insert_lookup_top
// Sends words one letter per request (insert, exact search, prefix search and
// the spare kind), keeps its own copy of the tree to predict each word's
// response, and checks every response in order. Runs directed words, random
// words under four idling mixes, and finally fills the node pool to overflow.
// ----------------------------------------------------------------------------
module tb_prefix_tree_insert_lookup_top;
   import pti_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE = KIND_W'(3);
   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 16;
   localparam int BANK_SIZE     = 512;
   localparam int WORD_MAX      = 16;
   localparam int RANDOM_ITEMS  = 1100;

   typedef struct packed {
      logic answer;
      logic status;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pti_req_if req_ch ();
   pti_rsp_if rsp_ch ();

   prefix_tree_insert_lookup_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [NODE_W-1:0] tree_child [NODES*ALPHABET];
   bit                tree_word_end [NODES];
   int                tree_nodes;
   int                tree_cursor;
   bit                tree_missed;
   bit                tree_overflow;
   verdict_type       expected_verdicts [$];

   int src_idle_pct  = 0;
   int snk_stall_pct = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;
   int letters_sent  = 0;

   logic [LETTER_W-1:0] word_buf [WORD_MAX];
   int                  word_len;
   logic [LETTER_W-1:0] bank [BANK_SIZE][WORD_MAX];
   int                  bank_len [BANK_SIZE];
   int                  bank_count = 0;

   function automatic void predict_letter(input logic [KIND_W-1:0] kind,
                                          input logic [LETTER_W-1:0] letter,
                                          input logic last);
      int          slot;
      int          next_node;
      verdict_type v;
      if (!tree_missed && !tree_overflow) begin
         if (letter >= ALPHABET) begin
            tree_missed = 1'b1;
         end else begin
            slot      = tree_cursor * ALPHABET + int'(letter);
            next_node = int'(tree_child[slot]);
            if (next_node == 0) begin
               if (kind != KIND_INSERT) begin
                  tree_missed = 1'b1;
               end else if (tree_nodes >= NODES) begin
                  tree_overflow = 1'b1;
               end else begin
                  next_node        = tree_nodes;
                  tree_child[slot] = NODE_W'(next_node);
                  tree_nodes++;
               end
            end
            if (!tree_missed && !tree_overflow) tree_cursor = next_node;
         end
      end
      if (last) begin
         v.answer = 1'b0;
         v.status = tree_overflow;
         if (!tree_missed && !tree_overflow) begin
            case (kind)
               KIND_INSERT: begin
                  tree_word_end[tree_cursor] = 1'b1;
                  v.answer = 1'b1;
               end
               KIND_EXACT: begin
                  v.answer = tree_word_end[tree_cursor];
               end
               default: begin
                  v.answer = 1'b1;
               end
            endcase
         end
         expected_verdicts.insert(expected_verdicts.size(), v);
         tree_cursor   = 0;
         tree_missed   = 1'b0;
         tree_overflow = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected response: answer %0d status %0d",
                   rsp_ch.answer, rsp_ch.status);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_ch.answer !== want.answer) begin
               $error("answer: expected %0d, got %0d", want.answer, rsp_ch.answer);
               error_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               error_count++;
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_letter(input logic [KIND_W-1:0] kind,
                              input logic [LETTER_W-1:0] letter,
                              input logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= kind;
      req_ch.letter <= letter;
      req_ch.last   <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_letter(kind, letter, last);
      letters_sent++;
   endtask

   task automatic send_word(input logic [KIND_W-1:0] kind, input bit mixed);
      for (int i = 0; i < word_len; i++) begin
         send_letter(mixed ? KIND_W'($urandom_range(3)) : kind, word_buf[i],
                     i == word_len - 1);
      end
   endtask

   task automatic set_word(input int n, input logic [LETTER_W-1:0] a,
                           input logic [LETTER_W-1:0] b = '0,
                           input logic [LETTER_W-1:0] c = '0);
      word_len    = n;
      word_buf[0] = a;
      word_buf[1] = b;
      word_buf[2] = c;
   endtask

   function automatic logic [LETTER_W-1:0] pick_letter();
      int r;
      r = $urandom_range(99);
      if (r < 70) return LETTER_W'($urandom_range(3));
      if (r < 96) return LETTER_W'($urandom_range(ALPHABET - 1));
      return LETTER_W'($urandom_range(31, ALPHABET));
   endfunction

   task automatic random_word(input int n, input bit full_span);
      word_len = n;
      for (int i = 0; i < n; i++) begin
         word_buf[i] = full_span ? LETTER_W'($urandom_range(ALPHABET - 1)) : pick_letter();
      end
   endtask

   task automatic load_bank_word();
      int idx;
      idx      = $urandom_range(bank_count - 1);
      word_buf = bank[idx];
      word_len = bank_len[idx];
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_word_op();
      int pick;
      int r;
      pick = $urandom_range(99);
      if (pick < 40 || bank_count == 0) begin
         random_word($urandom_range(6, 1), 1'b0);
         if (bank_count < BANK_SIZE) begin
            bank[bank_count]     = word_buf;
            bank_len[bank_count] = word_len;
            bank_count++;
         end
         send_word(KIND_INSERT, 1'b0);
      end else if (pick < 65) begin
         load_bank_word();
         r = $urandom_range(99);
         if (r < 25) begin
            word_len = $urandom_range(word_len, 1);
         end else if (r < 40 && word_len < WORD_MAX) begin
            word_buf[word_len] = pick_letter();
            word_len++;
         end
         send_word(KIND_EXACT, 1'b0);
      end else if (pick < 80) begin
         load_bank_word();
         word_len = $urandom_range(word_len, 1);
         send_word(($urandom_range(9) == 0) ? KIND_SPARE : KIND_PREFIX, 1'b0);
      end else if (pick < 92) begin
         random_word($urandom_range(6, 1), 1'b0);
         send_word(KIND_W'($urandom_range(3)), 1'b0);
      end else begin
         load_bank_word();
         send_word(KIND_INSERT, 1'b1);
      end
   endtask

   task automatic test_directed_words();
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      set_word(1, 0);
      send_word(KIND_EXACT, 1'b0);
      send_word(KIND_INSERT, 1'b0);
      send_word(KIND_EXACT, 1'b0);
      set_word(2, 25, 25);
      send_word(KIND_INSERT, 1'b0);
      set_word(1, 25);
      send_word(KIND_EXACT, 1'b0);
      send_word(KIND_PREFIX, 1'b0);
      set_word(2, 25, 25);
      send_word(KIND_SPARE, 1'b0);
      // out-of-alphabet letters miss and leave the tree alone
      set_word(2, 0, 31);
      send_word(KIND_INSERT, 1'b0);
      set_word(3, LETTER_W'(ALPHABET), 0, 0);
      send_word(KIND_INSERT, 1'b0);
      // mixed kinds: insert creates b, exact search then misses on c
      send_letter(KIND_INSERT, 1, 1'b0);
      send_letter(KIND_EXACT, 2, 1'b1);
      set_word(1, 1);
      send_word(KIND_PREFIX, 1'b0);
      set_word(2, 2, 1);
      send_word(KIND_INSERT, 1'b0);
      send_word(KIND_EXACT, 1'b0);
      set_word(2, 16, 15);
      send_word(KIND_EXACT, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_words();
      int stop_at;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
            default: begin src_idle_pct = 33; snk_stall_pct = 33; end
         endcase
         stop_at = letters_sent + RANDOM_ITEMS / 4;
         while (letters_sent < stop_at) random_word_op();
         wait_idle();
      end
   endtask

   task automatic test_pool_exhaustion();
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      while (tree_nodes < NODES) begin
         random_word(12, 1'b1);
         send_word(KIND_INSERT, 1'b0);
      end
      random_word(4, 1'b1);
      send_word(KIND_INSERT, 1'b0);
      send_word(KIND_EXACT, 1'b0);
      send_word(KIND_PREFIX, 1'b0);
      // overflow inside an insert, then an exact search ends the word
      random_word(3, 1'b1);
      send_letter(KIND_INSERT, word_buf[0], 1'b0);
      send_letter(KIND_INSERT, word_buf[1], 1'b0);
      send_letter(KIND_EXACT, word_buf[2], 1'b1);
      repeat (6) begin
         load_bank_word();
         send_word(KIND_EXACT, 1'b0);
         send_word(KIND_INSERT, 1'b0);
      end
      src_idle_pct  = 33;
      snk_stall_pct = 33;
      repeat (25) random_word_op();
      wait_idle();
   endtask

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.kind   = KIND_INSERT;
      req_ch.letter = '0;
      req_ch.last   = 1'b0;
      foreach (tree_child[i]) tree_child[i] = '0;
      tree_nodes    = 1;
      tree_cursor   = 0;
      tree_missed   = 1'b0;
      tree_overflow = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_words();
      test_random_words();
      test_pool_exhaustion();
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/pti_pkg.sv
rtl/pti_req_if.sv
rtl/pti_rsp_if.sv
rtl/pti_store.sv
rtl/prefix_tree_insert_lookup_top.sv
rtl/pti_checker.sv
tb/sv/tb_prefix_tree_insert_lookup_top.sv
